FILE: sv/vcu8_pkg.sv
// shared types and constants of the valid-region 2d convolution block
`timescale 1ns / 1ps
package vcu8_pkg;
   localparam int MAX_LINE   = 2048;
   localparam int KMAX       = 5;
   localparam int FRAC_BITS  = 8;
   localparam int HIST       = KMAX - 1;
   localparam int HIST_SLOTS = (HIST > 0) ? HIST : 1;
   localparam int LB_AW      = $clog2(MAX_LINE);
   localparam int NTAP       = KMAX * KMAX;
   localparam int TAP_W      = $clog2(NTAP + 1);
   localparam int KDIM_W     = $clog2(KMAX + 1) + 1;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = PIX_W + COEF_W + 1;
   localparam int COLSUM_W   = PROD_W + $clog2(KMAX) + 1;
   localparam int TOT_W      = COLSUM_W + $clog2(KMAX) + 1;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;
   localparam int CNT_W      = 17;

   // register indexes
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_KERNEL_ROWS  = 2'd2;
   localparam logic [1:0] REG_KERNEL_COLS  = 2'd3;

   // input item codes
   localparam logic OP_COEF  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   typedef logic [PIX_W-1:0]               pix_type;
   typedef logic signed [COEF_W-1:0]       coef_type;
   typedef pix_type  [KMAX-1:0]            col_pix_type;
   typedef coef_type [KMAX-1:0]            col_wt_type;
   typedef logic [HIST_SLOTS*PIX_W-1:0]    hist_type;
   typedef logic signed [COLSUM_W-1:0]     colsum_type;

   // line buffer control from the front stage
   typedef struct packed {
      logic              rd_en;
      logic [LB_AW-1:0]  rd_addr;
      logic              wr_en;
      logic [LB_AW-1:0]  wr_addr;
   } lb_ctrl_type;

   // per-beat tag carried down the pipe
   typedef struct packed {
      logic res;
      logic last;
   } tag_type;
endpackage

FILE: sv/vcu8_line_buf.sv
// line history memory, one word per column holding the previous lines
`timescale 1ns / 1ps
module vcu8_line_buf (
   input  logic                  clock,
   input  vcu8_pkg::lb_ctrl_type ctrl,
   input  vcu8_pkg::pix_type     pix,
   output vcu8_pkg::hist_type    hist
);
   import vcu8_pkg::*;

   hist_type mem [MAX_LINE];
   hist_type rd_ff;
   hist_type fwd_ff;
   logic     hit_ff;
   hist_type wr_data;

   assign hist = hit_ff ? fwd_ff : rd_ff;

   // newest first: incoming pixel goes to slot 0, older ones move down
   always_comb begin
      wr_data = hist;
      if (HIST > 1) begin
         wr_data = {hist[HIST_SLOTS*PIX_W-PIX_W-1:0], pix};
      end else begin
         wr_data = hist_type'(pix);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_ff  <= mem[ctrl.rd_addr];
         // same column written on this edge: take the new word
         hit_ff <= ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr);
         fwd_ff <= wr_data;
      end
   end
endmodule

FILE: sv/vcu8_cell.sv
// one window column: shifts pixels along the chain and sums its products
`timescale 1ns / 1ps
module vcu8_cell (
   input  logic                  clock,
   input  logic                  shift,
   input  vcu8_pkg::col_pix_type col_in,
   input  vcu8_pkg::col_wt_type  col_wt,
   output vcu8_pkg::col_pix_type col_out,
   output vcu8_pkg::colsum_type  col_sum
);
   import vcu8_pkg::*;

   col_pix_type                pix_ff;
   logic signed [PROD_W-1:0]   prod_ff [KMAX];
   colsum_type                 sum_ff;
   colsum_type                 sum_in;

   assign col_out = pix_ff;
   assign col_sum = sum_ff;

   always_comb begin
      sum_in = '0;
      for (int r = 0; r < KMAX; r++) begin
         sum_in = sum_in + COLSUM_W'(prod_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         pix_ff <= col_in;
      end
      // zero-weight taps may still hold unset pixels, keep them out of the sum
      for (int r = 0; r < KMAX; r++) begin
         prod_ff[r] <= (col_wt[r] == '0) ? '0 :
                       PROD_W'($signed({1'b0, pix_ff[r]})) * PROD_W'(col_wt[r]);
      end
      sum_ff <= sum_in;
   end
endmodule

FILE: sv/valid_2d_convolution_u8_top.sv
// valid-region 2d convolution of an 8-bit stream, top level
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_stall  | req_op, req_pixel, req_coef_index, req_coef_value
//  rsp     | out | rsp_valid/rsp_stall  | rsp_out_pixel, rsp_frame_last
//  csr     | in  | psel/penable/pready  | paddr, pwrite, pwdata, prdata
// one beat per cycle unless req is stalled; a result passes these registered steps after its pixel beat
// (line buffer read, window shift, products, column sums, total sum)
// an 8-entry result queue absorbs rsp stalls; req stalls once 8 results are owed
// synchronous active-high reset clears counters, weights and queue, and sets the registers to their defaults
`timescale 1ns / 1ps
module valid_2d_convolution_u8_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [7:0]                     req_pixel,
   input  logic [4:0]                     req_coef_index,
   input  logic signed [15:0]             req_coef_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_pixel,
   output logic                           rsp_frame_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [vcu8_pkg::ADDR_W-1:0]    paddr,
   input  logic [vcu8_pkg::DATA_W-1:0]    pwdata,
   output logic [vcu8_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);
   import vcu8_pkg::*;

   // configuration
   logic [11:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  krows_ff;
   logic [2:0]  kcols_ff;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 16'd480;
         krows_ff  <= 3'd3;
         kcols_ff  <= 3'd3;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[11:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[15:0];
            REG_KERNEL_ROWS:  krows_ff  <= pwdata[2:0];
            REG_KERNEL_COLS:  kcols_ff  <= pwdata[2:0];
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_IMAGE_WIDTH:  prdata = DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = DATA_W'(height_ff);
         REG_KERNEL_ROWS:  prdata = DATA_W'(krows_ff);
         REG_KERNEL_COLS:  prdata = DATA_W'(kcols_ff);
         default:          prdata = '0;
      endcase
   end

   // effective sizes
   logic [CNT_W-1:0]  w_eff;
   logic [CNT_W-1:0]  h_eff;
   logic [KDIM_W-1:0] kr_eff;
   logic [KDIM_W-1:0] kc_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CNT_W'(1);
      end else if (CNT_W'(width_ff) > CNT_W'(MAX_LINE)) begin
         w_eff = CNT_W'(MAX_LINE);
      end else begin
         w_eff = CNT_W'(width_ff);
      end
      h_eff = (height_ff == '0) ? CNT_W'(1) : CNT_W'(height_ff);
      if (krows_ff == '0) begin
         kr_eff = KDIM_W'(1);
      end else if (KDIM_W'(krows_ff) > KDIM_W'(KMAX)) begin
         kr_eff = KDIM_W'(KMAX);
      end else begin
         kr_eff = KDIM_W'(krows_ff);
      end
      if (kcols_ff == '0) begin
         kc_eff = KDIM_W'(1);
      end else if (KDIM_W'(kcols_ff) > KDIM_W'(KMAX)) begin
         kc_eff = KDIM_W'(KMAX);
      end else begin
         kc_eff = KDIM_W'(kcols_ff);
      end
   end

   // input acceptance and result credits
   logic                 acc;
   logic                 acc_pix;
   logic [FIFO_AW:0]     credit_ff;
   logic [FIFO_AW:0]     credit_in;
   logic                 pop;

   assign req_stall = (credit_ff >= (FIFO_AW+1)'(FIFO_DEPTH));
   assign acc       = req_valid && !req_stall;
   assign acc_pix   = acc && (req_op == OP_PIXEL);

   // raster counters
   logic [10:0]       col_cnt_ff;
   logic [15:0]       row_cnt_ff;
   logic [CNT_W-1:0]  cc1;
   logic [CNT_W-1:0]  rc1;
   logic              win_ok;
   logic              end_line;
   logic              end_frame;

   assign cc1       = CNT_W'(col_cnt_ff) + CNT_W'(1);
   assign rc1       = CNT_W'(row_cnt_ff) + CNT_W'(1);
   assign win_ok    = (rc1 >= CNT_W'(kr_eff)) && (cc1 >= CNT_W'(kc_eff)) &&
                      (CNT_W'(row_cnt_ff) < h_eff) && (CNT_W'(col_cnt_ff) < w_eff);
   assign end_line  = cc1 >= w_eff;
   assign end_frame = end_line && (rc1 >= h_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (acc_pix) begin
         if (end_frame) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= '0;
         end else if (end_line) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= row_cnt_ff + 16'd1;
         end else begin
            col_cnt_ff <= col_cnt_ff + 11'd1;
         end
      end
   end

   // weight table
   coef_type wt_ff [NTAP];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NTAP; i++) begin
            wt_ff[i] <= '0;
         end
      end else if (acc && (req_op == OP_COEF) && (TAP_W'(req_coef_index) < TAP_W'(NTAP))) begin
         wt_ff[req_coef_index] <= req_coef_value;
      end
   end

   // weight for every window position under the current kernel size
   col_wt_type pos_wt_in [KMAX];
   col_wt_type pos_wt_ff [KMAX];

   always_comb begin
      logic [KDIM_W-1:0] ro;
      logic [KDIM_W-1:0] co;
      logic [KDIM_W-1:0] rr;
      logic [KDIM_W-1:0] cc;
      logic [TAP_W-1:0]  wi;
      ro = KDIM_W'(KMAX) - kr_eff;
      co = KDIM_W'(KMAX) - kc_eff;
      for (int c = 0; c < KMAX; c++) begin
         for (int r = 0; r < KMAX; r++) begin
            rr = KDIM_W'(r) - ro;
            cc = KDIM_W'(c) - co;
            wi = TAP_W'(rr) * TAP_W'(kc_eff) + TAP_W'(cc);
            if ((KDIM_W'(r) >= ro) && (KDIM_W'(c) >= co)) begin
               pos_wt_in[c][r] = wt_ff[wi];
            end else begin
               pos_wt_in[c][r] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_wt_ff <= pos_wt_in;
   end

   // front stage
   logic              s1_v_ff;
   pix_type           s1_pix_ff;
   logic [LB_AW-1:0]  s1_col_ff;
   tag_type           s1_tag_ff;
   logic [LB_AW-1:0]  col_addr;
   lb_ctrl_type       lb_ctrl;
   hist_type          hist;

   assign col_addr = (CNT_W'(col_cnt_ff) < CNT_W'(MAX_LINE)) ? LB_AW'(col_cnt_ff)
                                                             : LB_AW'(MAX_LINE - 1);
   assign lb_ctrl.rd_en   = acc_pix;
   assign lb_ctrl.rd_addr = col_addr;
   assign lb_ctrl.wr_en   = s1_v_ff;
   assign lb_ctrl.wr_addr = s1_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s1_tag_ff <= '0;
      end else begin
         s1_v_ff       <= acc_pix;
         s1_tag_ff.res  <= acc_pix && win_ok;
         s1_tag_ff.last <= end_frame;
      end
      if (acc_pix) begin
         s1_pix_ff <= req_pixel;
         s1_col_ff <= col_addr;
      end
   end

   vcu8_line_buf u_line_buf (
      .clock (clock),
      .ctrl  (lb_ctrl),
      .pix   (s1_pix_ff),
      .hist  (hist)
   );

   // new window column: incoming pixel at the bottom, history above it
   col_pix_type new_col;

   always_comb begin
      new_col = '0;
      new_col[KMAX-1] = s1_pix_ff;
      for (int k = 1; k <= HIST; k++) begin
         new_col[KMAX-1-k] = hist[(k-1)*PIX_W +: PIX_W];
      end
   end

   // chain of window columns, newest on the right
   col_pix_type cell_out [KMAX];
   colsum_type  cell_sum [KMAX];

   for (genvar c = 0; c < KMAX; c++) begin : g_cell
      col_pix_type cin;
      if (c == KMAX - 1) begin : g_last
         assign cin = new_col;
      end else begin : g_mid
         assign cin = cell_out[c+1];
      end
      vcu8_cell u_cell (
         .clock   (clock),
         .shift   (s1_v_ff),
         .col_in  (cin),
         .col_wt  (pos_wt_ff[c]),
         .col_out (cell_out[c]),
         .col_sum (cell_sum[c])
      );
   end

   // tag pipe matching the cell latency
   tag_type t2_ff;
   tag_type t3_ff;
   tag_type t4_ff;
   tag_type t5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_ff <= '0;
         t3_ff <= '0;
         t4_ff <= '0;
         t5_ff <= '0;
      end else begin
         t2_ff <= s1_tag_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
         t5_ff <= t4_ff;
      end
   end

   // total, clamp and round
   logic signed [TOT_W-1:0] tot_ff;
   logic signed [TOT_W-1:0] tot_in;
   logic signed [TOT_W-1:0] clamped;
   logic signed [TOT_W-1:0] top_val;
   logic [TOT_W-1:0]        rounded;
   pix_type                 res_pix;

   assign top_val = TOT_W'(255) <<< FRAC_BITS;

   always_comb begin
      tot_in = '0;
      for (int c = 0; c < KMAX; c++) begin
         tot_in = tot_in + TOT_W'(cell_sum[c]);
      end
      if (tot_ff < 0) begin
         clamped = '0;
      end else if (tot_ff > top_val) begin
         clamped = top_val;
      end else begin
         clamped = tot_ff;
      end
      rounded = (TOT_W'(clamped) + (TOT_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      res_pix = rounded[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      tot_ff <= tot_in;
   end

   // result queue
   pix_type             q_pix_ff  [FIFO_DEPTH];
   logic                q_last_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff;
   logic [FIFO_AW-1:0]  rd_ptr_ff;
   logic [FIFO_AW:0]    q_cnt_ff;
   logic                push;

   assign push           = t5_ff.res;
   assign rsp_valid      = (q_cnt_ff != '0);
   assign pop            = rsp_valid && !rsp_stall;
   assign rsp_out_pixel  = q_pix_ff[rd_ptr_ff];
   assign rsp_frame_last = q_last_ff[rd_ptr_ff];

   always_comb begin
      credit_in = credit_ff;
      if ((acc_pix && win_ok) && !pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (!(acc_pix && win_ok) && pop) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_pix_ff[wr_ptr_ff]  <= res_pix;
         q_last_ff[wr_ptr_ff] <= t5_ff.last;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            q_cnt_ff <= q_cnt_ff + 1'b1;
         end else if (!push && pop) begin
            q_cnt_ff <= q_cnt_ff - 1'b1;
         end
      end
   end
endmodule

FILE: sv/vcu8_checker.sv
// port-level checks for the convolution top level, bound to it
`timescale 1ns / 1ps
module vcu8_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_op,
   input logic [7:0]                   req_pixel,
   input logic [4:0]                   req_coef_index,
   input logic signed [15:0]           req_coef_value,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [7:0]                   rsp_out_pixel,
   input logic                         rsp_frame_last,
   input logic                         psel,
   input logic                         penable,
   input logic                         pwrite,
   input logic [vcu8_pkg::ADDR_W-1:0]  paddr,
   input logic [vcu8_pkg::DATA_W-1:0]  pwdata,
   input logic [vcu8_pkg::DATA_W-1:0]  prdata,
   input logic                         pready
);
   // a result beat waiting on stall stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped under stall");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_pixel) && $stable(rsp_frame_last))
      else $error("rsp payload changed under stall");

   // reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // no result is offered just after reset unless an input beat was taken in between
   a_no_early: assert property (@(posedge clock)
      $past(reset) && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("result without a pixel beat");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      psel && penable |-> pready)
      else $error("pready low during access");
endmodule

bind valid_2d_convolution_u8_top vcu8_checker u_vcu8_checker (.*);

FILE: dv/tb_top.sv
// testbench for the valid-region 2d convolution block: table, random frames, running predictor
`timescale 1ns / 1ps
module tb_top;
   import vcu8_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 12;

   typedef struct {
      logic        op;
      logic [7:0]  pixel;
      logic [4:0]  index;
      logic [15:0] value;
      bit          pinned;
      logic [7:0]  exp_pixel;
      bit          exp_last;
   } stim_row_type;

   typedef struct {
      logic [7:0] pixel;
      bit         last;
   } out_pix_type;

   typedef struct {
      bit          on;
      out_pix_type val;
   } pin_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op = OP_PIXEL;
   logic [7:0]        req_pixel = '0;
   logic [4:0]        req_coef_index = '0;
   logic signed [15:0] req_coef_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_out_pixel;
   logic              rsp_frame_last;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   valid_2d_convolution_u8_top i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [11:0] cfg_width = 12'd640;
   logic [15:0] cfg_height = 16'd480;
   logic [2:0]  cfg_krows = 3'd3;
   logic [2:0]  cfg_kcols = 3'd3;
   logic [7:0]  col_history [HIST_SLOTS*MAX_LINE];
   logic [7:0]  window [NTAP];
   int          weights [NTAP];
   int unsigned col_cnt = 0;
   int unsigned row_cnt = 0;

   out_pix_type pending_q [$];
   pin_type     pin_q [$];
   int          fail_cnt = 0;
   int          quiet_cycles = 0;
   int          tx_idle_pct = 20;
   int          rx_idle_pct = 73;

   function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // advance the convolution state by one beat; returns 1 when an output pixel results
   function automatic bit convolve_beat(logic op, logic [7:0] pix, logic [4:0] index,
                                        logic [15:0] value, output out_pix_type res);
      int unsigned w, h, kr, kc, col, widx;
      logic [7:0]  column [KMAX];
      bit          in_window, end_line, end_frame;
      longint      acc;
      res = '{pixel: 8'd0, last: 1'b0};
      w  = clampu(cfg_width, 1, MAX_LINE);
      h  = clampu(cfg_height, 1, 65535);
      kr = clampu(cfg_krows, 1, KMAX);
      kc = clampu(cfg_kcols, 1, KMAX);
      if (op == OP_COEF) begin
         if (index < NTAP) weights[index] = $signed(value);
         return 1'b0;
      end
      col = (col_cnt < MAX_LINE) ? col_cnt : MAX_LINE - 1;
      column[KMAX-1] = pix;
      for (int k = 1; k < KMAX; k++) column[KMAX-1-k] = col_history[col*HIST_SLOTS + k - 1];
      for (int k = HIST; k > 1; k--)
         col_history[col*HIST_SLOTS + k - 1] = col_history[col*HIST_SLOTS + k - 2];
      if (HIST > 0) col_history[col*HIST_SLOTS] = pix;
      for (int r = 0; r < KMAX; r++) begin
         for (int c = 0; c + 1 < KMAX; c++) window[r*KMAX + c] = window[r*KMAX + c + 1];
         window[r*KMAX + KMAX - 1] = column[r];
      end
      in_window = (row_cnt + 1 >= kr) && (col_cnt + 1 >= kc) && (row_cnt < h) && (col_cnt < w);
      end_line  = col_cnt + 1 >= w;
      end_frame = end_line && (row_cnt + 1 >= h);
      if (in_window) begin
         acc = 0;
         for (int r = 0; r < kr; r++)
            for (int c = 0; c < kc; c++) begin
               widx = r*kc + c;
               if (widx < NTAP)
                  acc += longint'(window[(KMAX-kr+r)*KMAX + (KMAX-kc+c)]) * weights[widx];
            end
         if (acc < 0) acc = 0;
         if (acc > (longint'(255) << FRAC_BITS)) acc = longint'(255) << FRAC_BITS;
         res.pixel = 8'((acc + (longint'(1) << (FRAC_BITS-1))) >> FRAC_BITS);
         res.last  = end_frame;
      end
      if (end_frame) begin
         col_cnt = 0;
         row_cnt = 0;
      end else if (end_line) begin
         col_cnt = 0;
         row_cnt = (row_cnt + 1) & 16'hFFFF;
      end else begin
         col_cnt = (col_cnt + 1) & 11'h7FF;
      end
      return in_window;
   endfunction

   // sample mid-cycle: every value here is what the next rising edge sees
   always @(negedge clock) begin
      out_pix_type res, exp_v;
      pin_type     pin;
      bit          fire;
      if (!reset) begin
         fire = 1'b0;
         if (req_valid && !req_stall) begin
            fire = 1'b1;
            pin.on = 1'b0;
            if (pin_q.size()) pin = pin_q.pop_front();
            if (convolve_beat(req_op, req_pixel, req_coef_index, req_coef_value, res)) begin
               if (pin.on) res = pin.val;
               pending_q = {pending_q, res};
            end
         end
         if (rsp_valid && !rsp_stall) begin
            fire = 1'b1;
            if (pending_q.size() == 0) begin
               $error("unexpected beat out_pixel %0d frame_last %0d",
                      rsp_out_pixel, rsp_frame_last);
               fail_cnt++;
            end else begin
               exp_v = pending_q.pop_front();
               if (rsp_out_pixel !== exp_v.pixel) begin
                  $error("out_pixel expected %0d actual %0d", exp_v.pixel, rsp_out_pixel);
                  fail_cnt++;
               end
               if (rsp_frame_last !== exp_v.last) begin
                  $error("frame_last expected %0d actual %0d", exp_v.last, rsp_frame_last);
                  fail_cnt++;
               end
            end
         end
         if (psel && penable) fire = 1'b1;
         quiet_cycles = fire ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   always @(posedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < rx_idle_pct);

   task automatic send_beat(logic op, logic [7:0] pix, logic [4:0] index, logic [15:0] value);
      bit stalled;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_pixel      <= pix;
      req_coef_index <= index;
      req_coef_value <= value;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic send_pixel(logic [7:0] pix);
      send_beat(OP_PIXEL, pix, 5'($urandom), 16'($urandom));
   endtask

   task automatic send_coef(logic [4:0] index, logic [15:0] value);
      send_beat(OP_COEF, 8'($urandom), index, value);
   endtask

   // wait out results in flight, then the pipe latency
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_q.size()) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(index) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_IMAGE_WIDTH:  cfg_width  = value[11:0];
         REG_IMAGE_HEIGHT: cfg_height = value[15:0];
         REG_KERNEL_ROWS:  cfg_krows  = value[2:0];
         default:          cfg_kcols  = value[2:0];
      endcase
   endtask

   task automatic set_geometry(int w, int h, int kr, int kc);
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_KERNEL_ROWS, kr);
      csr_write(REG_KERNEL_COLS, kc);
   endtask

   // mild weights keep most sums out of the clamps
   task automatic load_weights();
      for (int i = 0; i < NTAP; i++) send_coef(5'(i), 16'(int'($urandom_range(0, 160)) - 40));
   endtask

   function automatic int frame_beats();
      return clampu(cfg_width, 1, MAX_LINE) * clampu(cfg_height, 1, 65535);
   endfunction

   // 4x3 frame, 2x2 kernel, only the newest tap weighted
   stim_row_type dir_table [] = '{
      '{OP_COEF,  8'hFF, 5'd3,  16'h0100, 0, 8'd0,   0},
      '{OP_COEF,  8'h00, 5'd31, 16'h7FFF, 0, 8'd0,   0},
      '{OP_COEF,  8'h00, 5'd25, 16'h8000, 0, 8'd0,   0},
      '{OP_PIXEL, 8'd0,   5'd0, 16'h0000, 0, 8'd0,   0},
      '{OP_PIXEL, 8'd255, 5'd31, 16'hFFFF, 0, 8'd0,  0},
      '{OP_PIXEL, 8'd1,   5'd0, 16'h0000, 0, 8'd0,   0},
      '{OP_PIXEL, 8'd2,   5'd0, 16'h0000, 0, 8'd0,   0},
      '{OP_PIXEL, 8'd10,  5'd0, 16'h0000, 0, 8'd0,   0},
      '{OP_PIXEL, 8'd255, 5'd0, 16'h0000, 1, 8'd255, 0},
      '{OP_PIXEL, 8'd0,   5'd0, 16'h0000, 1, 8'd0,   0},
      '{OP_PIXEL, 8'd128, 5'd0, 16'h0000, 1, 8'd128, 0},
      '{OP_PIXEL, 8'd7,   5'd0, 16'h0000, 0, 8'd0,   0},
      '{OP_COEF,  8'h00, 5'd3,  16'h8000, 0, 8'd0,   0},
      '{OP_PIXEL, 8'd255, 5'd0, 16'h0000, 1, 8'd0,   0},
      '{OP_COEF,  8'h00, 5'd3,  16'h7FFF, 0, 8'd0,   0},
      '{OP_PIXEL, 8'd1,   5'd0, 16'h0000, 1, 8'd128, 0},
      '{OP_COEF,  8'h00, 5'd3,  16'h0080, 0, 8'd0,   0},
      '{OP_PIXEL, 8'd3,   5'd0, 16'h0000, 1, 8'd2,   1},
      '{OP_PIXEL, 8'd9,   5'd0, 16'h0000, 0, 8'd0,   0}
   };

   initial begin
      int      beats;
      int      nframes;
      pin_type pin_row;
      for (int i = 0; i < HIST_SLOTS*MAX_LINE; i++) col_history[i] = '0;
      for (int i = 0; i < NTAP; i++) begin
         window[i]  = '0;
         weights[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_geometry(4, 3, 2, 2);
      foreach (dir_table[i]) begin
         pin_row.on  = dir_table[i].pinned;
         pin_row.val = '{pixel: dir_table[i].exp_pixel, last: dir_table[i].exp_last};
         pin_q = {pin_q, pin_row};
         send_beat(dir_table[i].op, dir_table[i].pixel, dir_table[i].index, dir_table[i].value);
      end
      // the trailing pixel opened a new frame; close it before reconfiguring
      for (int i = 1; i < 12; i++) send_pixel(8'($urandom));
      drain();

      beats = 0;
      while (beats < 1370) begin
         if (beats < 457) begin
            tx_idle_pct = 20;
            rx_idle_pct = 73;
         end else if (beats < 914) begin
            tx_idle_pct = 73;
            rx_idle_pct = 20;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         // out-of-range sizes included: zero, and kernels beyond five
         set_geometry($urandom_range(0, 12), $urandom_range(0, 7),
                      $urandom_range(0, 7), $urandom_range(0, 7));
         if ($urandom_range(3) == 0) begin
            load_weights();
            beats += NTAP;
         end
         nframes = $urandom_range(1, 2);
         for (int f = 0; f < nframes; f++)
            for (int p = 0; p < frame_beats(); p++) begin
               if ($urandom_range(9) == 0) begin
                  send_coef(5'($urandom), 16'($urandom));
                  beats++;
               end
               send_pixel(8'($urandom));
               beats++;
            end
         drain();
      end

      // tallest frame, left open at the end of the run
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_geometry(3, 65535, 5, 3);
      load_weights();
      repeat (300) send_pixel(8'($urandom));
      drain();

      if (fail_cnt == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
